FILE: rtl/objwb_pkg.sv
package objwb_pkg;

   // Value and coefficient formats
   localparam int VALUE_W = 32;          // unsigned Q16.16
   localparam int COEF_W  = 26;          // unsigned Q10.16
   localparam int Q_FRAC  = 16;
   localparam int QUOT_W  = COEF_W + 1;  // quotient bits kept before the clamp

   typedef logic [VALUE_W-1:0] value_type;
   typedef logic [COEF_W-1:0]  coef_type;

   localparam coef_type COEF_MAX = coef_type'(65536000);  // 1000.0

   // Objective count is fixed by the payload ports
   localparam int NUM_OBJ = 4;
   localparam int OBJ_W   = $clog2(NUM_OBJ);

   localparam int DEF_WINDOW_DEPTH = 8;

   // Transaction kinds
   localparam logic REQ_INIT   = 1'b0;
   localparam logic REQ_UPDATE = 1'b1;

   // Register file
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = VALUE_W;
   localparam logic [CSR_IDX_W-1:0] CSR_TINY_VALUE    = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_RECOMP_PERIOD = 1'b1;

   localparam value_type  TINY_VALUE_RST    = value_type'(1);
   localparam logic [7:0] RECOMP_PERIOD_RST = 8'd8;

endpackage

FILE: rtl/objective_weight_balancer.sv
// Objective weight balancer. Keeps a window of the last WINDOW_DEPTH values of
// four objectives (unsigned Q16.16) and reports one Q10.16 coefficient per
// objective, coef_i = sum_0 / sum_i, truncated and clamped at 1000.0; a zero
// divisor also gives 1000.0. An init transaction (req_type 0) fills each
// window row with its value (objective 0's value where it is zero) and sets
// the coefficients at once; an update transaction (req_type 1) writes one
// window column, and once per recompute period (register 1) of updates all
// coefficients are recomputed.
// Every transaction returns exactly one response with the current
// coefficients. All arithmetic runs on one shared adder and one restoring
// divider that retires a quotient bit per cycle, under a small sequencer; the
// block takes no new transaction until the current one is finished. An update
// writes its window column; with a recompute, the window sweep then reads and
// accumulates each entry, and each coefficient takes a divider start and then
// one divider step per quotient bit; a saturating coefficient skips the steps.
// An init skips the write and the sweep. A response waiting on rsp_ready does
// not block acceptance of the next request.
module objective_weight_balancer #(
   parameter int WINDOW_DEPTH = objwb_pkg::DEF_WINDOW_DEPTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // configuration
   input  logic                                 csr_we,
   input  logic [objwb_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [objwb_pkg::CSR_DATA_W-1:0]     csr_wdata,
   // requests
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_type,
   input  objwb_pkg::value_type                 req_obj_value_0,
   input  objwb_pkg::value_type                 req_obj_value_1,
   input  objwb_pkg::value_type                 req_obj_value_2,
   input  objwb_pkg::value_type                 req_obj_value_3,
   // responses
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_recomputed,
   output objwb_pkg::coef_type                  rsp_coef_0,
   output objwb_pkg::coef_type                  rsp_coef_1,
   output objwb_pkg::coef_type                  rsp_coef_2,
   output objwb_pkg::coef_type                  rsp_coef_3
);
   import objwb_pkg::*;

   localparam int COL_W   = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int SUM_W   = VALUE_W + $clog2(WINDOW_DEPTH);
   localparam int NUM_W   = SUM_W + Q_FRAC;
   localparam int HI_W    = NUM_W - QUOT_W;
   localparam int ADDR_W  = OBJ_W + COL_W;
   localparam int ENTRIES = 1 << ADDR_W;
   localparam int STEP_W  = $clog2(QUOT_W);

   localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(WINDOW_DEPTH - 1);
   localparam logic [OBJ_W-1:0]  OBJ_LAST  = OBJ_W'(NUM_OBJ - 1);
   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(QUOT_W - 1);

   // sequencer states
   localparam logic [2:0] ST_IDLE      = 3'd0;
   localparam logic [2:0] ST_WRITE     = 3'd1;
   localparam logic [2:0] ST_SUM_RD    = 3'd2;
   localparam logic [2:0] ST_SUM_ACC   = 3'd3;
   localparam logic [2:0] ST_DIV_START = 3'd4;
   localparam logic [2:0] ST_DIV_STEP  = 3'd5;
   localparam logic [2:0] ST_DONE      = 3'd6;

   logic [2:0]        state_ff, state_in;
   logic [OBJ_W-1:0]  obj_ff, obj_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [COL_W-1:0]  pos_ff, pos_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [7:0]        cnt_ff, cnt_in;
   logic              recomp_ff, recomp_in;
   value_type         tiny_ff;
   logic [7:0]        interval_ff;

   value_type         v_ff[NUM_OBJ], v_in[NUM_OBJ];
   value_type         row_fill_ff[NUM_OBJ], row_fill_in[NUM_OBJ];
   logic [SUM_W-1:0]  sum_ff[NUM_OBJ], sum_in[NUM_OBJ];
   coef_type          coef_ff[NUM_OBJ], coef_in[NUM_OBJ];
   logic [SUM_W-1:0]  acc_ff, acc_in;
   logic [SUM_W-1:0]  rem_ff, rem_in;
   logic [QUOT_W-1:0] quo_ff, quo_in;
   logic [ENTRIES-1:0] vld_ff, vld_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_recomp_ff, rsp_recomp_in;
   coef_type          rsp_coef_ff[NUM_OBJ], rsp_coef_in[NUM_OBJ];

   // window memory
   value_type         win_mem[ENTRIES];
   value_type         rd_data_ff;
   logic              vld_rd_ff;
   logic              mem_we;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   value_type         wr_data;

   value_type         in_val[NUM_OBJ];
   value_type         fill;
   logic [7:0]        cnt_next;
   logic [SUM_W-1:0]  term, acc_sum, den;
   logic [NUM_W-1:0]  num_ext;
   logic [HI_W-1:0]   num_hi;
   logic              overflow;
   logic [SUM_W:0]    rem_sh, rem_diff;
   logic              take;
   logic [SUM_W-1:0]  rem_next;
   logic [QUOT_W-1:0] quo_next;
   coef_type          coef_res;

   assign in_val[0] = req_obj_value_0;
   assign in_val[1] = req_obj_value_1;
   assign in_val[2] = req_obj_value_2;
   assign in_val[3] = req_obj_value_3;

   assign req_ready = (state_ff == ST_IDLE);

   // memory ports
   assign mem_we  = (state_ff == ST_WRITE);
   assign wr_addr = {obj_ff, pos_ff};
   assign rd_addr = {obj_ff, col_ff};
   assign wr_data = (v_ff[obj_ff] == '0) ? tiny_ff : v_ff[obj_ff];

   always_ff @(posedge clock) begin
      if (mem_we) begin
         win_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= win_mem[rd_addr];
      vld_rd_ff  <= vld_ff[rd_addr];
   end

   // row sum accumulation; an unwritten entry reads as its row fill value
   assign term    = vld_rd_ff ? SUM_W'(rd_data_ff) : SUM_W'(row_fill_ff[obj_ff]);
   assign acc_sum = ((col_ff == '0) ? '0 : acc_ff) + term;

   // shared divider: sum_0 * 2^16 / sum_obj
   assign den      = sum_ff[obj_ff];
   assign num_ext  = {sum_ff[0], {Q_FRAC{1'b0}}};
   assign num_hi   = num_ext[NUM_W-1 -: HI_W];
   // quotient at least 2^27 saturates; a zero divisor always lands here too
   assign overflow = (SUM_W'(num_hi) >= den);
   assign rem_sh   = {rem_ff, quo_ff[QUOT_W-1]};
   assign take     = (rem_sh >= {1'b0, den});
   assign rem_diff = rem_sh - {1'b0, den};
   assign rem_next = take ? rem_diff[SUM_W-1:0] : rem_sh[SUM_W-1:0];
   assign quo_next = {quo_ff[QUOT_W-2:0], take};
   assign coef_res = (quo_next > QUOT_W'(COEF_MAX)) ? COEF_MAX : quo_next[COEF_W-1:0];

   // sequencer
   always_comb begin
      state_in      = state_ff;
      obj_in        = obj_ff;
      col_in        = col_ff;
      pos_in        = pos_ff;
      step_in       = step_ff;
      cnt_in        = cnt_ff;
      recomp_in     = recomp_ff;
      v_in          = v_ff;
      row_fill_in   = row_fill_ff;
      sum_in        = sum_ff;
      coef_in       = coef_ff;
      acc_in        = acc_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      vld_in        = vld_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_recomp_in = rsp_recomp_ff;
      rsp_coef_in   = rsp_coef_ff;
      fill          = '0;
      cnt_next      = 8'(cnt_ff + 8'd1);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               obj_in = '0;
               if (req_type == REQ_INIT) begin
                  for (int i = 0; i < NUM_OBJ; i++) begin
                     fill           = (in_val[i] != '0) ? in_val[i] : in_val[0];
                     row_fill_in[i] = fill;
                     sum_in[i]      = SUM_W'(fill);
                  end
                  vld_in    = '0;
                  recomp_in = 1'b1;
                  state_in  = ST_DIV_START;
               end else begin
                  pos_in = (pos_ff == COL_LAST) ? '0 : COL_W'(pos_ff + 1'b1);
                  v_in   = in_val;
                  if (cnt_next == interval_ff) begin
                     cnt_in    = '0;
                     recomp_in = 1'b1;
                  end else begin
                     cnt_in    = cnt_next;
                     recomp_in = 1'b0;
                  end
                  state_in = ST_WRITE;
               end
            end
         end
         ST_WRITE: begin
            vld_in[wr_addr] = 1'b1;
            if (obj_ff == OBJ_LAST) begin
               obj_in   = '0;
               col_in   = '0;
               state_in = recomp_ff ? ST_SUM_RD : ST_DONE;
            end else begin
               obj_in = OBJ_W'(obj_ff + 1'b1);
            end
         end
         ST_SUM_RD: begin
            state_in = ST_SUM_ACC;
         end
         ST_SUM_ACC: begin
            acc_in   = acc_sum;
            state_in = ST_SUM_RD;
            if (col_ff == COL_LAST) begin
               sum_in[obj_ff] = acc_sum;
               col_in         = '0;
               if (obj_ff == OBJ_LAST) begin
                  obj_in   = '0;
                  state_in = ST_DIV_START;
               end else begin
                  obj_in = OBJ_W'(obj_ff + 1'b1);
               end
            end else begin
               col_in = COL_W'(col_ff + 1'b1);
            end
         end
         ST_DIV_START: begin
            if (overflow) begin
               coef_in[obj_ff] = COEF_MAX;
               if (obj_ff == OBJ_LAST) begin
                  state_in = ST_DONE;
               end else begin
                  obj_in = OBJ_W'(obj_ff + 1'b1);
               end
            end else begin
               rem_in   = SUM_W'(num_hi);
               quo_in   = num_ext[QUOT_W-1:0];
               step_in  = '0;
               state_in = ST_DIV_STEP;
            end
         end
         ST_DIV_STEP: begin
            rem_in = rem_next;
            quo_in = quo_next;
            if (step_ff == STEP_LAST) begin
               coef_in[obj_ff] = coef_res;
               if (obj_ff == OBJ_LAST) begin
                  state_in = ST_DONE;
               end else begin
                  obj_in   = OBJ_W'(obj_ff + 1'b1);
                  state_in = ST_DIV_START;
               end
            end else begin
               step_in = STEP_W'(step_ff + 1'b1);
            end
         end
         ST_DONE: begin
            // hand over once the response register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_recomp_in = recomp_ff;
               rsp_coef_in   = coef_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         obj_ff       <= '0;
         col_ff       <= '0;
         pos_ff       <= '0;
         step_ff      <= '0;
         cnt_ff       <= '0;
         recomp_ff    <= 1'b0;
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_OBJ; i++) begin
            row_fill_ff[i] <= '0;
            coef_ff[i]     <= '0;
         end
      end else begin
         state_ff     <= state_in;
         obj_ff       <= obj_in;
         col_ff       <= col_in;
         pos_ff       <= pos_in;
         step_ff      <= step_in;
         cnt_ff       <= cnt_in;
         recomp_ff    <= recomp_in;
         vld_ff       <= vld_in;
         rsp_valid_ff <= rsp_valid_in;
         row_fill_ff  <= row_fill_in;
         coef_ff      <= coef_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      v_ff          <= v_in;
      sum_ff        <= sum_in;
      acc_ff        <= acc_in;
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      rsp_recomp_ff <= rsp_recomp_in;
      rsp_coef_ff   <= rsp_coef_in;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         tiny_ff     <= TINY_VALUE_RST;
         interval_ff <= RECOMP_PERIOD_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TINY_VALUE:    tiny_ff     <= csr_wdata[VALUE_W-1:0];
            CSR_RECOMP_PERIOD: interval_ff <= csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_recomputed = rsp_recomp_ff;
   assign rsp_coef_0     = rsp_coef_ff[0];
   assign rsp_coef_1     = rsp_coef_ff[1];
   assign rsp_coef_2     = rsp_coef_ff[2];
   assign rsp_coef_3     = rsp_coef_ff[3];

   // checks
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff != ST_IDLE)
      else $error("sequencer idle straight after an accepted transaction");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff) == ST_DONE)
      else $error("response raised outside the completion state");

   a_div_remainder: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV_STEP |-> rem_ff < sum_ff[obj_ff])
      else $error("divider remainder not below divisor");

   a_coef_clamped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_coef_0 <= COEF_MAX && rsp_coef_1 <= COEF_MAX &&
                    rsp_coef_2 <= COEF_MAX && rsp_coef_3 <= COEF_MAX)
      else $error("coefficient above clamp");

endmodule
